@@ hdl/steq_pkg.sv @@
package steq_pkg;
  localparam int QueueDepth = 32;
  localparam int IdxW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_EXPIRE = 2'd1;
  localparam logic [1:0] REQ_PROGRAM = 2'd2;

  localparam logic [2:0] KIND_ADDED = 3'd0;
  localparam logic [2:0] KIND_ADD_ERR = 3'd1;
  localparam logic [2:0] KIND_EXPIRED = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd3;
  localparam logic [2:0] KIND_COMPARE = 3'd4;

  localparam logic CFG_TICK_RATE = 1'b0;
  localparam logic CFG_FALLBACK = 1'b1;

  typedef struct packed {
    logic [63:0] expiry;
    logic [7:0] handle;
    logic [31:0] tag;
  } entry_t;
endpackage

@@ hdl/steq_ram.sv @@
// One-write, one-read entry memory with registered read data.
module steq_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [steq_pkg::IdxW-1:0] waddr,
  input  steq_pkg::entry_t         wdata,
  input  logic [steq_pkg::IdxW-1:0] raddr,
  output steq_pkg::entry_t         rdata
);
  import steq_pkg::*;

  entry_t mem [QueueDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/sorted_timer_event_queue.sv @@
// Sorted timer event queue: up to 32 events kept in ascending expiry order in one
// memory. Issue a request with start while busy is low; results come one per
// strobe on out_valid, with out_last on the final one, and cannot be held off.
// Configuration writes are taken only while the block is idle. A rejected add and
// a no-handle zero-delay add give their result the cycle after the request and
// keep the block idle. An accepted add walks the table from the tail toward its
// slot, one read then one write per step, moving each later entry up by one. An
// expire reads entries from the head, then compacts the survivors. A program
// request keeps the block busy while it reports the earlier of the head entry's
// expiry, if any, and now plus the fallback. The memory has a single read port,
// and that port paces every walk. No clearing pass is needed.
module sorted_timer_event_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_now_ticks,
  input  logic [7:0]  in_handle_id,
  input  logic [31:0] in_user_tag,
  input  logic signed [31:0] in_delay_seconds,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_handle,
  output logic [31:0] out_tag,
  output logic [63:0] out_compare_value,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import steq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD_RD, S_ADD_CHK, S_ADD_WR,
    S_EXP_RD, S_EXP_CHK, S_SH_RD, S_SH_WR, S_PRG_RD, S_PRG_CHK
  } state_t;

  state_t      state_r;
  logic [31:0] tick_rate_r;
  logic [26:0] fallback_r;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] ptr_r;   // walk pointer
  logic [CntW-1:0] npop_r;  // entries popped
  logic [63:0] now_r, prod_r, expiry_r;
  logic [7:0]  handle_r;
  logic [31:0] tag_r, delay_r;

  logic        we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  steq_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state_r != S_IDLE);
  // Take register writes only between requests.
  assign cfg_ready = (state_r == S_IDLE);

  // Memory access per state.
  always_comb begin
    we = 1'b0;
    waddr = ptr_r[IdxW-1:0];
    wdata = rdata;
    raddr = ptr_r[IdxW-1:0];
    unique case (state_r)
      S_ADD_RD: raddr = IdxW'(ptr_r - 1'b1);
      S_ADD_CHK: begin
        // move predecessor up, or place the new entry
        we = 1'b1;
        if (ptr_r != 0 && rdata.expiry > expiry_r) begin
          wdata = rdata;
        end else begin
          wdata = '{expiry: expiry_r, handle: handle_r, tag: tag_r};
        end
      end
      S_SH_WR: begin
        we = 1'b1;
        waddr = IdxW'(ptr_r - npop_r);
      end
      S_PRG_RD: raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      tick_rate_r <= 32'd10000000;
      fallback_r <= 27'd312500;
      out_last <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TICK_RATE) tick_rate_r <= cfg_data;
        else fallback_r <= cfg_data[26:0];
      end
      unique case (state_r)
        S_IDLE: if (start) begin
          now_r <= in_now_ticks;
          handle_r <= in_handle_id;
          tag_r <= in_user_tag;
          delay_r <= in_delay_seconds;
          ptr_r <= count_r;
          npop_r <= '0;
          out_handle <= '0;
          out_tag <= '0;
          // only a no-handle zero-delay add reports a compare time here
          out_compare_value <= (in_req_type == REQ_ADD && in_handle_id == 8'd0 &&
                                in_delay_seconds == 32'sd0) ? in_now_ticks : '0;
          out_last <= 1'b1;
          unique case (in_req_type)
            REQ_ADD: begin
              if (in_handle_id == 8'd0 && in_delay_seconds == 32'sd0) begin
                out_valid <= 1'b1;
                out_kind <= KIND_COMPARE;
              end else if (in_handle_id == 8'd0 || in_delay_seconds[31] ||
                           count_r >= CntW'(QueueDepth)) begin
                out_valid <= 1'b1;
                out_kind <= KIND_ADD_ERR;
              end else begin
                state_r <= S_MUL;
              end
            end
            REQ_EXPIRE: begin
              ptr_r <= '0;
              state_r <= S_EXP_RD;
            end
            REQ_PROGRAM: state_r <= S_PRG_RD;
            default: ;
          endcase
        end
        S_MUL: begin
          prod_r <= {32'd0, delay_r} * {32'd0, tick_rate_r};
          state_r <= S_ADD_RD;
        end
        S_ADD_RD: begin
          expiry_r <= now_r + prod_r;
          state_r <= S_ADD_CHK;
        end
        S_ADD_CHK: begin
          // advance down while predecessor is later
          if (ptr_r != 0 && rdata.expiry > expiry_r) begin
            ptr_r <= ptr_r - 1'b1;
            state_r <= S_ADD_RD;
          end else begin
            count_r <= count_r + 1'b1;
            out_valid <= 1'b1;
            out_kind <= KIND_ADDED;
            state_r <= S_IDLE;
          end
        end
        S_EXP_RD: begin
          if (ptr_r >= count_r) begin
            count_r <= '0;
            out_valid <= 1'b1;
            out_kind <= KIND_DONE;
            out_handle <= '0;
            out_tag <= '0;
            out_last <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_EXP_CHK;
          end
        end
        S_EXP_CHK: begin
          if (rdata.expiry <= now_r) begin
            out_valid <= 1'b1;
            out_kind <= KIND_EXPIRED;
            out_handle <= rdata.handle;
            out_tag <= rdata.tag;
            out_last <= 1'b0;
            npop_r <= npop_r + 1'b1;
            ptr_r <= ptr_r + 1'b1;
            state_r <= S_EXP_RD;
          end else if (npop_r == 0) begin
            out_valid <= 1'b1;
            out_kind <= KIND_DONE;
            out_handle <= '0;
            out_tag <= '0;
            out_last <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SH_WR;
          end
        end
        S_SH_RD: begin
          if (ptr_r >= count_r) begin
            count_r <= count_r - npop_r;
            out_valid <= 1'b1;
            out_kind <= KIND_DONE;
            out_handle <= '0;
            out_tag <= '0;
            out_last <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          // rdata holds entry ptr_r; copied down by npop_r
          ptr_r <= ptr_r + 1'b1;
          state_r <= S_SH_RD;
        end
        S_PRG_RD: begin
          expiry_r <= now_r + {37'd0, fallback_r};
          state_r <= S_PRG_CHK;
        end
        S_PRG_CHK: begin
          out_valid <= 1'b1;
          out_kind <= KIND_COMPARE;
          out_compare_value <= (count_r != 0 && rdata.expiry < expiry_r) ?
                               rdata.expiry : expiry_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/steq_checker.sv @@
module steq_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last,
  input logic [2:0] out_kind
);
  import steq_pkg::*;

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("busy after last result");
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("idle mid-sequence");
  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EXPIRED |-> !out_last)
    else $error("expired entry marked last");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_last) else $error("done not last");
endmodule

bind sorted_timer_event_queue steq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_last(out_last), .out_kind(out_kind)
);
